// ===== rtl/osrq_pkg.sv =====
`default_nettype none
package osrq_pkg;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int FIELD9_W = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/osrq_if.sv =====
`default_nettype none
interface osrq_in_if;
  import osrq_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   item_key;
  modport source (output valid, cmd, item_key, input ready);
  modport sink   (input valid, cmd, item_key, output ready);
endinterface

interface osrq_out_if;
  import osrq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD9_W-1:0] rank;
  logic [FIELD9_W-1:0] occupancy;
  modport source (output valid, status, rank, occupancy, input ready);
  modport sink   (input valid, status, rank, occupancy, output ready);
endinterface
`default_nettype wire

// ===== rtl/osrq_ctrl.sv =====
`default_nettype none
module osrq_ctrl
  import osrq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   dp_cmd
);
  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/osrq_dp.sv =====
`default_nettype none
module osrq_dp
  import osrq_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             dp_cmd,
  input  wire logic [CMD_W-1:0]    cmd,
  input  wire logic [KEY_W-1:0]    item_key,
  output logic [STATUS_W-1:0]      status,
  output logic [FIELD9_W-1:0]      rank,
  output logic [FIELD9_W-1:0]      occupancy
);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // shifting sorted store: each cell compares in parallel
  logic [KEY_BITS-1:0] cells [CAPACITY];
  logic [CNT_W-1:0]    count;
  logic [CMD_W-1:0]    op;
  logic [KEY_BITS-1:0] key;

  logic [CAPACITY-1:0] lt;  // cell valid and below key
  logic [CAPACITY-1:0] eq;  // cell valid and equal to key
  logic [CNT_W-1:0]    pos;
  logic                present;
  logic                full;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count) && (cells[i] < key);
      eq[i] = (CNT_W'(i) < count) && (cells[i] == key);
    end
  end

  // valid cells are sorted, so lt is a run of ones from the bottom
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt[i]) begin
        pos = CNT_W'(i + 1);
      end
    end
  end

  assign present = |eq;
  assign full    = (count == CNT_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op  <= cmd;
      key <= item_key[KEY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      if (op == CMD_INSERT && !present && !full) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == pos) begin
            cells[i] <= key;
          end else if (CNT_W'(i) > pos && i > 0) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (op == CMD_REMOVE && present) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (CNT_W'(i) >= pos) begin
            cells[i] <= cells[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.exec) begin
      if (op == CMD_INSERT && !present && !full) begin
        count <= count + 1'b1;
      end else if (op == CMD_REMOVE && present) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      status <= ST_DONE;
      rank   <= '0;
      unique case (op)
        CMD_INSERT: begin
          if (present) begin
            status <= ST_DUP;
          end else if (full) begin
            status <= ST_FULL;
          end
        end
        CMD_REMOVE: begin
          if (!present) begin
            status <= ST_ABSENT;
          end
        end
        CMD_QUERY: begin
          if (present) begin
            rank <= FIELD9_W'(pos + 1'b1);
          end else begin
            status <= ST_ABSENT;
          end
        end
        default: ;
      endcase
    end
  end

  assign occupancy = FIELD9_W'(count);
endmodule
`default_nettype wire

// ===== rtl/ordered_set_rank_query.sv =====
// from input beat to output beat the command and key are loaded, then executed into
// the result registers
// the controller walks idle, execute and present with one item in flight at
// a time; no new item is taken until the result beat is accepted
// reset: synchronous active-high rst empties the set and idles the controller
`default_nettype none
module ordered_set_rank_query
  import osrq_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  osrq_in_if.sink    in_ch,
  osrq_out_if.source out_ch
);
  // command bundle from controller to datapath
  dp_cmd_t dp_cmd;

  osrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd)
  );

  // sorted store with parallel compare; results held until the beat is taken
  osrq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .cmd       (in_ch.cmd),
    .item_key  (in_ch.item_key),
    .status    (out_ch.status),
    .rank      (out_ch.rank),
    .occupancy (out_ch.occupancy)
  );
endmodule
`default_nettype wire

// ===== rtl/osrq_checker.sv =====
`default_nettype none
module osrq_checker
  import osrq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [FIELD9_W-1:0] rank
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("out beat dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && rank != '0 |-> status == ST_DONE) else $error("rank on failure");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind ordered_set_rank_query osrq_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .rank      (out_ch.rank)
);
`default_nettype wire
